### src/gcpd_pkg.sv
// Shared types and command codes for the GPU command port decoder.
// No dependencies; imported by the decoder and its port checker.
package gcpd_pkg;

	typedef enum logic [1:0] {
		OP_GP0_WRITE  = 2'd0,
		OP_GP1_WRITE  = 2'd1,
		OP_READ_DATA  = 2'd2,
		OP_READ_STAT  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		PH_READY  = 3'd0,
		PH_COLOR  = 3'd1,
		PH_VERTEX = 3'd2,
		PH_COORD  = 3'd3,
		PH_SIZE   = 3'd4,
		PH_DATA   = 3'd5
	} phase_t;

	localparam logic [7:0]  NO_CMD        = 8'hFF;
	localparam logic [31:0] STATUS_RESET  = 32'h1C00_0000;

	// GP0 headers
	localparam logic [7:0] GP0_NOP0        = 8'h00;
	localparam logic [7:0] GP0_NOP1        = 8'h01;
	localparam logic [7:0] GP0_MONO_QUAD   = 8'h28;
	localparam logic [7:0] GP0_SHADED_TRI  = 8'h30;
	localparam logic [7:0] GP0_SHADED_QUAD = 8'h38;
	localparam logic [7:0] GP0_LOAD_IMAGE  = 8'hA0;
	localparam logic [7:0] GP0_STORE_IMAGE = 8'hC0;
	localparam logic [7:0] GP0_TEXPAGE     = 8'hE1;
	localparam logic [7:0] GP0_TEX_WINDOW  = 8'hE2;
	localparam logic [7:0] GP0_AREA_TL     = 8'hE3;
	localparam logic [7:0] GP0_AREA_BR     = 8'hE4;
	localparam logic [7:0] GP0_OFFSET      = 8'hE5;
	localparam logic [7:0] GP0_MASK_BITS   = 8'hE6;

	// GP1 commands
	localparam logic [7:0] GP1_SOFT_RESET   = 8'h00;
	localparam logic [7:0] GP1_ABORT        = 8'h01;
	localparam logic [7:0] GP1_ACK_IRQ      = 8'h02;
	localparam logic [7:0] GP1_DISP_ENABLE  = 8'h03;
	localparam logic [7:0] GP1_DMA_DIR      = 8'h04;
	localparam logic [7:0] GP1_DISP_START   = 8'h05;
	localparam logic [7:0] GP1_HORIZ_RANGE  = 8'h06;
	localparam logic [7:0] GP1_VERT_RANGE   = 8'h07;
	localparam logic [7:0] GP1_DISPLAY_MODE = 8'h08;

endpackage

### src/gpu_command_port_decoder_unit.sv
// GPU command port decoder: GP0 packet parser, GP1 display control, status read.
// Depends on gcpd_pkg.
//
// Usage:
//   Input channel (in_valid / in_stall, op, word) carries one port access per
//   item: GP0 write, GP1 write, data read or status read. Output channel
//   (out_valid / out_stall) returns exactly one result item per input item:
//   read_data, one vertex with its colour and polygon_last, command_error.
//   Latency: the result appears in the cycle after the item is accepted.
//   Throughput: one item per cycle unless stalled; all decode runs in the
//   accept cycle and the result is held in a single output register.
//   Stall: while a result waits under out_stall, in_stall is raised; when the
//   result is taken, a new item can be accepted in the same cycle.
//   Reset: arst_n clears the output valid flag and sets the status word to its
//   ready value with no packet open. GP1 soft reset restores display state
//   but keeps the ready bits.
//   Image load data words are counted and dropped; VRAM-to-CPU headers are
//   consumed. Unknown or unsupported commands give command_error.
module gpu_command_port_decoder_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  op,
	input  logic [31:0] word,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] read_data,
	output logic        vertex_valid,
	output logic [15:0] vertex_x,
	output logic [15:0] vertex_y,
	output logic [23:0] vertex_color,
	output logic        polygon_last,
	output logic        command_error
);
	import gcpd_pkg::*;

	logic [31:0] status_q,  status_d;
	logic [7:0]  cmd_q,     cmd_d;
	phase_t      phase_q,   phase_d;
	logic [2:0]  vcount_q,  vcount_d;
	logic [23:0] color_q,   color_d;
	logic [30:0] left_q,    left_d;

	logic        out_valid_q;
	logic [31:0] rdata_d,  rdata_q;
	logic        vvalid_d, vvalid_q;
	logic [15:0] vx_d,     vx_q;
	logic [15:0] vy_d,     vy_q;
	logic [23:0] vcolor_d, vcolor_q;
	logic        plast_d,  plast_q;
	logic        err_d,    err_q;

	logic        accept;
	logic [7:0]  hdr;
	logic        is_poly;
	logic [2:0]  vcount_inc;
	logic [2:0]  poly_len;
	logic [31:0] pixels;
	logic [32:0] pixels_inc;

	assign in_stall   = out_valid_q & out_stall;
	assign accept     = in_valid & ~in_stall;
	assign hdr        = word[31:24];
	assign is_poly    = (cmd_q == GP0_MONO_QUAD) || (cmd_q == GP0_SHADED_TRI) ||
		(cmd_q == GP0_SHADED_QUAD);
	assign vcount_inc = vcount_q + 3'd1;
	assign poly_len   = (cmd_q == GP0_SHADED_TRI) ? 3'd3 : 3'd4;
	assign pixels     = {16'd0, word[15:0]} * {16'd0, word[31:16]};
	assign pixels_inc = {1'b0, pixels} + 33'd1;

	// next state
	always_comb begin
		status_d = status_q;
		cmd_d    = cmd_q;
		phase_d  = phase_q;
		vcount_d = vcount_q;
		color_d  = color_q;
		left_d   = left_q;
		unique case (op_t'(op))
			OP_GP0_WRITE: begin
				if (cmd_q == NO_CMD) begin
					unique case (hdr)
						GP0_MONO_QUAD, GP0_SHADED_TRI, GP0_SHADED_QUAD: begin
							cmd_d    = hdr;
							phase_d  = PH_VERTEX;
							vcount_d = 3'd0;
							color_d  = word[23:0];
						end
						GP0_LOAD_IMAGE, GP0_STORE_IMAGE: begin
							cmd_d   = hdr;
							phase_d = PH_COORD;
						end
						GP0_TEXPAGE: begin
							status_d[9:0] = word[9:0];
							status_d[15]  = word[11];
						end
						GP0_MASK_BITS: begin
							status_d[11] = word[0];
							status_d[12] = word[1];
						end
						default: ;  // nops, environment words with no status effect, errors
					endcase
				end else if (is_poly) begin
					if (phase_q == PH_COLOR) begin
						color_d = word[23:0];
						phase_d = PH_VERTEX;
					end else begin
						vcount_d = vcount_inc;
						if (vcount_inc >= poly_len) begin
							cmd_d    = NO_CMD;
							phase_d  = PH_READY;
							vcount_d = 3'd0;
							left_d   = '0;
						end else if (cmd_q != GP0_MONO_QUAD) begin
							phase_d = PH_COLOR;
						end
					end
				end else begin
					priority case (phase_q)
						PH_COORD: phase_d = PH_SIZE;
						PH_SIZE: begin
							if (cmd_q == GP0_LOAD_IMAGE && pixels_inc[31:1] != '0) begin
								left_d  = pixels_inc[31:1];
								phase_d = PH_DATA;
							end else begin
								cmd_d    = NO_CMD;
								phase_d  = PH_READY;
								vcount_d = 3'd0;
								left_d   = '0;
							end
						end
						PH_DATA: begin
							left_d = left_q - 31'd1;
							if (left_q == 31'd1) begin
								cmd_d    = NO_CMD;
								phase_d  = PH_READY;
								vcount_d = 3'd0;
							end
						end
						default: begin
							cmd_d    = NO_CMD;
							phase_d  = PH_READY;
							vcount_d = 3'd0;
							left_d   = '0;
						end
					endcase
				end
			end
			OP_GP1_WRITE: begin
				unique case (hdr)
					GP1_SOFT_RESET: begin
						cmd_d    = NO_CMD;
						phase_d  = PH_READY;
						vcount_d = 3'd0;
						left_d   = '0;
						status_d[24]    = 1'b0;
						status_d[23]    = 1'b1;
						status_d[30:29] = 2'b00;
						status_d[18:17] = 2'b01;
						status_d[22:19] = 4'b0000;
						status_d[16]    = 1'b0;
						status_d[14]    = 1'b0;
						status_d[9:0]   = '0;
						status_d[15]    = 1'b0;
						status_d[12:11] = 2'b00;
					end
					GP1_ABORT: begin
						cmd_d    = NO_CMD;
						phase_d  = PH_READY;
						vcount_d = 3'd0;
						left_d   = '0;
					end
					GP1_ACK_IRQ:     status_d[24]    = 1'b0;
					GP1_DISP_ENABLE: status_d[23]    = word[0];
					GP1_DMA_DIR:     status_d[30:29] = word[1:0];
					GP1_DISPLAY_MODE: begin
						status_d[18:17] = word[1:0];
						status_d[19]    = 1'b0;
						status_d[20]    = word[3];
						status_d[21]    = word[4];
						status_d[22]    = word[5];
						status_d[16]    = word[6];
						status_d[14]    = word[7];
					end
					default: ;  // display start and ranges hold no status bits; unknown codes flag below
				endcase
			end
			OP_READ_DATA, OP_READ_STAT: ;
		endcase
	end

	// result item
	always_comb begin
		rdata_d  = '0;
		vvalid_d = 1'b0;
		vx_d     = '0;
		vy_d     = '0;
		vcolor_d = '0;
		plast_d  = 1'b0;
		err_d    = 1'b0;
		unique case (op_t'(op))
			OP_GP0_WRITE: begin
				if (cmd_q == NO_CMD) begin
					unique case (hdr)
						GP0_NOP0, GP0_NOP1, GP0_MONO_QUAD, GP0_SHADED_TRI,
						GP0_SHADED_QUAD, GP0_LOAD_IMAGE, GP0_STORE_IMAGE,
						GP0_TEXPAGE, GP0_TEX_WINDOW, GP0_AREA_TL, GP0_AREA_BR,
						GP0_OFFSET, GP0_MASK_BITS: err_d = 1'b0;
						default: err_d = 1'b1;
					endcase
				end else if (is_poly && phase_q != PH_COLOR) begin
					vvalid_d = 1'b1;
					vx_d     = word[15:0];
					vy_d     = word[31:16];
					vcolor_d = color_q;
					plast_d  = (vcount_inc >= poly_len);
				end
			end
			OP_GP1_WRITE: err_d = (hdr > GP1_DISPLAY_MODE);
			OP_READ_STAT: rdata_d = status_q;
			OP_READ_DATA: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_q    <= STATUS_RESET;
			cmd_q       <= NO_CMD;
			phase_q     <= PH_READY;
			vcount_q    <= 3'd0;
			color_q     <= '0;
			left_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				status_q    <= status_d;
				cmd_q       <= cmd_d;
				phase_q     <= phase_d;
				vcount_q    <= vcount_d;
				color_q     <= color_d;
				left_q      <= left_d;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rdata_q  <= rdata_d;
			vvalid_q <= vvalid_d;
			vx_q     <= vx_d;
			vy_q     <= vy_d;
			vcolor_q <= vcolor_d;
			plast_q  <= plast_d;
			err_q    <= err_d;
		end
	end

	assign out_valid     = out_valid_q;
	assign read_data     = rdata_q;
	assign vertex_valid  = vvalid_q;
	assign vertex_x      = vx_q;
	assign vertex_y      = vy_q;
	assign vertex_color  = vcolor_q;
	assign polygon_last  = plast_q;
	assign command_error = err_q;

endmodule

### src/gcpd_checker.sv
// Port-level checker for the GPU command port decoder, bound to the top level.
// Depends on gcpd_pkg.
module gcpd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic [1:0]  op,
	input logic [31:0] word,
	input logic        out_valid,
	input logic        out_stall,
	input logic [31:0] read_data,
	input logic        vertex_valid,
	input logic [15:0] vertex_x,
	input logic [15:0] vertex_y,
	input logic [23:0] vertex_color,
	input logic        polygon_last,
	input logic        command_error
);
	import gcpd_pkg::*;

	// a waiting result holds until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(read_data) &&
		$stable(vertex_valid) && $stable(vertex_x) && $stable(command_error))
		else $error("stalled result changed");

	// stall only comes from a waiting result
	a_no_idle_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled with empty output register");

	// every accepted item gives a result next cycle
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> out_valid)
		else $error("accepted item produced no result");

	// no vertex means zero vertex fields
	a_vertex_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !vertex_valid |-> vertex_x == 16'd0 && vertex_y == 16'd0 &&
		vertex_color == 24'd0 && !polygon_last)
		else $error("vertex fields set without vertex");

	// status reads always show the ready bits, with no vertex and no error
	a_status_read: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && op == OP_READ_STAT |=>
		read_data[28:26] == 3'b111 && !vertex_valid && !command_error)
		else $error("bad status read result");

endmodule

bind gpu_command_port_decoder_unit gcpd_checker u_gcpd_checker (.*);
